// ===== rtl/kli_pkg.sv =====
// ============================================================================
// Keyframe linear interpolator package
// Shared types, item codes and fixed-point constants.
// ============================================================================
`default_nettype none

package kli_pkg;

    // Item kinds carried on the input tuser.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Result status codes carried on the output tuser.
    localparam logic [2:0] ST_INTERP   = 3'd0;
    localparam logic [2:0] ST_SINGLE   = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_STORED   = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_ZERO_INT = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

    localparam int          FRAC_BITS  = 16;
    localparam logic [16:0] FACTOR_ONE = 17'h10000;

    // One stored key; the layout matches the input tdata word.
    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
        logic [31:0]        tstamp;
    } key_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_result_t;

endpackage

`default_nettype wire

// ===== rtl/keyframe_linear_interpolator_top.sv =====
// A clear or append item goes through S_DONE, which waits while the output is stalled, into
// the output register. A query on two or more stored keys runs a linear search with one
// key time read per cycle, reads the interval keys, runs the 16-bit serial divide unless the
// factor is 0 or 1, and makes three passes through one lerp unit for a nonzero interval.
// Only one item is in work; the next is accepted in the cycle after the result is registered.
// Reset empties the key table and the output; stored key contents stay undefined.
// ============================================================================
// Keyframe linear interpolator top level
// Key table in RAM, linear interval search, serial factor divide and a shared
// lerp unit under one sequencer.
// ============================================================================
`default_nettype none

module keyframe_linear_interpolator_top #(
    parameter int MAX_KEYS = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: time_ticks[31:0], value_x[63:32], value_y[95:64], value_z[127:96]
    input  wire logic [127:0] s_axis_tdata,
    // tuser: opcode[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: result_x[31:0], result_y[63:32], result_z[95:64], interval_index[101:96]
    output logic [103:0]      m_axis_tdata,
    // tuser: status[2:0]
    output logic [2:0]        m_axis_tuser
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int KW = $bits(kli_pkg::key_t);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SEARCH   = 4'd1;
    localparam logic [3:0] S_RD_START = 4'd2;
    localparam logic [3:0] S_RD_END   = 4'd3;
    localparam logic [3:0] S_SETUP    = 4'd4;
    localparam logic [3:0] S_FACTOR   = 4'd5;
    localparam logic [3:0] S_DIV      = 4'd6;
    localparam logic [3:0] S_LERP     = 4'd7;
    localparam logic [3:0] S_LERP_W   = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic                single_reg, single_next;
    logic [31:0]         qtime_reg, qtime_next;
    kli_pkg::key_t       start_reg, start_next;
    kli_pkg::key_t       end_reg, end_next;
    logic signed [32:0]  num_reg, num_next;
    logic signed [32:0]  den_reg, den_next;
    logic [16:0]         factor_reg, factor_next;
    logic [1:0]          comp_reg, comp_next;
    logic signed [31:0]  rx_reg, rx_next;
    logic signed [31:0]  ry_reg, ry_next;
    logic signed [31:0]  rz_reg, rz_next;
    logic [5:0]          ridx_reg, ridx_next;
    logic [2:0]          rstat_reg, rstat_next;

    logic                ovalid_reg, ovalid_next;
    logic signed [31:0]  ox_reg, ox_next;
    logic signed [31:0]  oy_reg, oy_next;
    logic signed [31:0]  oz_reg, oz_next;
    logic [5:0]          oidx_reg, oidx_next;
    logic [2:0]          ostat_reg, ostat_next;

    logic                ram_we;
    logic [AW-1:0]       ram_raddr;
    kli_pkg::key_t       ram_rdata;
    logic                in_fire;
    logic                issue;
    logic [AW+5:0]       idx_wide;
    logic [31:0]         an, ad;

    logic                div_start;
    kli_pkg::div_result_t div_res;
    logic                lerp_go;
    logic signed [31:0]  lerp_s, lerp_e, lerp_r;
    logic                lerp_done;

    kli_ram #(
        .WIDTH (KW),
        .DEPTH (MAX_KEYS)
    ) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_axis_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (an),
        .divisor  (ad),
        .result   (div_res)
    );

    kli_lerp u_lerp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lerp_go),
        .start_val (lerp_s),
        .end_val   (lerp_e),
        .factor    (factor_reg),
        .out_valid (lerp_done),
        .result    (lerp_r)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign idx_wide      = {6'd0, idx_reg};

    always_comb
    begin
        unique case (comp_reg)
            2'd0:    begin lerp_s = start_reg.x; lerp_e = end_reg.x; end
            2'd1:    begin lerp_s = start_reg.y; lerp_e = end_reg.y; end
            default: begin lerp_s = start_reg.z; lerp_e = end_reg.z; end
        endcase
        an = num_reg[32] ? 32'(33'sd0 - num_reg) : num_reg[31:0];
        ad = den_reg[32] ? 32'(33'sd0 - den_reg) : den_reg[31:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = 1'b0;
        idx_next       = idx_reg;
        single_next    = single_reg;
        qtime_next     = qtime_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        factor_next    = factor_reg;
        comp_next      = comp_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        rz_next        = rz_reg;
        ridx_next      = ridx_reg;
        rstat_next     = rstat_reg;
        ovalid_next    = ovalid_reg && !m_axis_tready;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oz_next        = oz_reg;
        oidx_next      = oidx_reg;
        ostat_next     = ostat_reg;
        ram_we         = 1'b0;
        ram_raddr      = idx_reg;
        issue          = 1'b0;
        div_start      = 1'b0;
        lerp_go        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    rx_next     = '0;
                    ry_next     = '0;
                    rz_next     = '0;
                    ridx_next   = '0;
                    idx_next    = '0;
                    single_next = 1'b0;
                    qtime_next  = s_axis_tdata[31:0];
                    state_next  = S_DONE;
                    if (s_axis_tuser == kli_pkg::OP_CLEAR)
                    begin
                        count_next = '0;
                        rstat_next = kli_pkg::ST_CLEARED;
                    end
                    else if (s_axis_tuser == kli_pkg::OP_APPEND)
                    begin
                        if (count_reg < CW'(MAX_KEYS))
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                            rstat_next = kli_pkg::ST_STORED;
                        end
                        else
                        begin
                            rstat_next = kli_pkg::ST_FULL;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        rstat_next = kli_pkg::ST_EMPTY;
                    end
                    else if (count_reg == CW'(1))
                    begin
                        single_next = 1'b1;
                        state_next  = S_RD_START;
                    end
                    else
                    begin
                        ptr_next   = CW'(1);
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                issue          = ptr_reg < count_reg;
                ram_raddr      = ptr_reg[AW-1:0];
                cmp_valid_next = issue;
                cmp_idx_next   = ptr_reg;
                if (issue)
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
                if (cmp_valid_reg && (qtime_reg < ram_rdata.tstamp))
                begin
                    idx_next       = AW'(cmp_idx_reg - CW'(1));
                    cmp_valid_next = 1'b0;
                    state_next     = S_RD_START;
                end
                else if (cmp_valid_reg && (cmp_idx_reg == count_reg - CW'(1)))
                begin
                    idx_next   = '0;
                    state_next = S_RD_START;
                end
            end

            S_RD_START:
            begin
                ram_raddr  = idx_reg;
                state_next = S_RD_END;
            end

            S_RD_END:
            begin
                ram_raddr  = idx_reg + AW'(1);
                start_next = ram_rdata;
                if (single_reg)
                begin
                    rx_next    = ram_rdata.x;
                    ry_next    = ram_rdata.y;
                    rz_next    = ram_rdata.z;
                    rstat_next = kli_pkg::ST_SINGLE;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SETUP;
                end
            end

            S_SETUP:
            begin
                end_next   = ram_rdata;
                den_next   = $signed({1'b0, ram_rdata.tstamp}) -
                             $signed({1'b0, start_reg.tstamp});
                num_next   = $signed({1'b0, qtime_reg}) - $signed({1'b0, start_reg.tstamp});
                ridx_next  = idx_wide[5:0];
                state_next = S_FACTOR;
            end

            S_FACTOR:
            begin
                comp_next = 2'd0;
                if (den_reg == '0)
                begin
                    rx_next    = start_reg.x;
                    ry_next    = start_reg.y;
                    rz_next    = start_reg.z;
                    rstat_next = kli_pkg::ST_ZERO_INT;
                    state_next = S_DONE;
                end
                else if (num_reg == '0 || (num_reg[32] != den_reg[32]))
                begin
                    factor_next = '0;
                    state_next  = S_LERP;
                end
                else if (an >= ad)
                begin
                    factor_next = kli_pkg::FACTOR_ONE;
                    state_next  = S_LERP;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_res.done)
                begin
                    factor_next = {1'b0, div_res.quotient};
                    state_next  = S_LERP;
                end
            end

            S_LERP:
            begin
                lerp_go    = 1'b1;
                state_next = S_LERP_W;
            end

            S_LERP_W:
            begin
                if (lerp_done)
                begin
                    unique case (comp_reg)
                        2'd0:    rx_next = lerp_r;
                        2'd1:    ry_next = lerp_r;
                        default: rz_next = lerp_r;
                    endcase
                    comp_next = comp_reg + 2'd1;
                    if (comp_reg == 2'd2)
                    begin
                        rstat_next = kli_pkg::ST_INTERP;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LERP;
                    end
                end
            end

            S_DONE:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    ox_next     = rx_reg;
                    oy_next     = ry_reg;
                    oz_next     = rz_reg;
                    oidx_next   = ridx_reg;
                    ostat_next  = rstat_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            cmp_idx_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            comp_reg      <= 2'd0;
            single_reg    <= 1'b0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            cmp_idx_reg   <= cmp_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            comp_reg      <= comp_next;
            single_reg    <= single_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        qtime_reg  <= qtime_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        factor_reg <= factor_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        rz_reg     <= rz_next;
        ridx_reg   <= ridx_next;
        rstat_reg  <= rstat_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        oz_reg     <= oz_next;
        oidx_reg   <= oidx_next;
        ostat_reg  <= ostat_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {2'b00, oidx_reg, oz_reg, oy_reg, ox_reg};
    assign m_axis_tuser  = ostat_reg;

endmodule

`default_nettype wire

// ===== rtl/kli_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module kli_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/kli_div.sv =====
// ============================================================================
// Interpolation factor divider
// Restoring divider producing (dividend << 16) / divisor, one bit per cycle.
// The dividend must be smaller than the divisor.
// ============================================================================
`default_nettype none

module kli_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [31:0]        dividend,
    input  wire logic [31:0]        divisor,
    output kli_pkg::div_result_t    result
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [15:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic        fits;

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, 1'b0};
        fits      = shifted >= {1'b0, dvs_reg};
        if (start)
        begin
            rem_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = 5'(kli_pkg::FRAC_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? 32'(shifted - {1'b0, dvs_reg}) : shifted[31:0];
            quo_next = {quo_reg[14:0], fits};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign result.done     = done_reg;
    assign result.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/kli_lerp.sv =====
// ============================================================================
// Shared lerp unit
// Computes start + factor * (end - start) / 65536 with truncation toward zero
// and signed 32-bit saturation, over two register stages.
// ============================================================================
`default_nettype none

module kli_lerp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic signed [31:0] start_val,
    input  wire logic signed [31:0] end_val,
    input  wire logic [16:0]        factor,
    output logic                    out_valid,
    output logic signed [31:0]      result
);

    logic signed [32:0] diff;
    logic signed [17:0] fac_s;
    logic signed [50:0] prod_next, prod_reg;
    logic signed [31:0] base_reg;
    logic               v1_reg, v2_reg;
    logic signed [50:0] adj;
    logic signed [34:0] quo;
    logic signed [35:0] sum;
    logic signed [31:0] sat, result_reg;

    always_comb
    begin
        diff      = 33'(end_val) - 33'(start_val);
        fac_s     = $signed({1'b0, factor});
        prod_next = 51'(diff) * 51'(fac_s);
    end

    always_comb
    begin
        adj = prod_reg + (prod_reg[50] ? 51'sd65535 : 51'sd0);
        quo = adj[50:16];
        sum = 36'(base_reg) + 36'(quo);
        if (sum[35:31] == 5'b00000 || sum[35:31] == 5'b11111)
        begin
            sat = sum[31:0];
        end
        else if (sum[35])
        begin
            sat = 32'sh80000000;
        end
        else
        begin
            sat = 32'sh7FFFFFFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        base_reg   <= start_val;
        result_reg <= sat;
    end

    assign out_valid = v2_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

// ===== rtl/kli_checker.sv =====
// ============================================================================
// Keyframe linear interpolator port checker
// Concurrent checks on the top-level ports, attached by a bind statement.
// ============================================================================
`default_nettype none

module kli_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [127:0] s_axis_tdata,
    input wire logic [1:0]   s_axis_tuser,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [103:0] m_axis_tdata,
    input wire logic [2:0]   m_axis_tuser
);

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item was in work");

    a_table_ops_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == kli_pkg::ST_CLEARED ||
                           m_axis_tuser == kli_pkg::ST_STORED ||
                           m_axis_tuser == kli_pkg::ST_FULL ||
                           m_axis_tuser == kli_pkg::ST_EMPTY))
        |-> (m_axis_tdata == '0))
        else $error("non-interpolated result carries nonzero data");

    a_single_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == kli_pkg::ST_SINGLE) |-> (m_axis_tdata[101:96] == '0))
        else $error("single-key result with nonzero interval index");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled output item changed");

endmodule

bind keyframe_linear_interpolator_top kli_checker u_kli_checker (.*);

`default_nettype wire
